@@ sv/lkv_pkg.sv @@
package lkv_pkg;

	// Width and reset value of the capacity register.
	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request codes carried on the action field.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Strobes into the line store for one cycle.
	typedef struct packed {
		logic line_re;  // read key and rank at the sweep address
		logic val_re;   // read the value of one line
		logic key_we;   // write the key of the line being filled
		logic val_we;   // write the value of a line
	} lkv_store_ctl_t;

	// Strobes into the scan unit for one cycle.
	typedef struct packed {
		logic clear;    // forget the previous request's scan results
		logic search;   // read data of one line is ready for the lookup sweep
		logic update;   // read data of one line is ready for the rank sweep
	} lkv_scan_ctl_t;

endpackage

@@ sv/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement. Each
// transaction on the input channel is a get (action 0) or a put (action 1) and
// produces exactly one transaction on the output channel: hit tells whether the
// key was present, read_value carries the stored value on a get that hits and
// zero otherwise, and evicted/evicted_key report the least recent line that a
// put of a new key pushed out once the fill reached the capacity register.
// The capacity register takes effect on the next put; zero reads as one and
// values above ENTRIES read as ENTRIES. The block works on one request at a
// time. A request sweeps the line store through its line read port, one line
// per cycle: a lookup pass that finds the key, the least recent line and the
// first free line, then, except on a get that misses, a rank pass that ages
// the lines. in_ready stays low from acceptance until the result has been
// moved into the output register, and a result left waiting there does not
// stop the next request from being accepted. The store is empty after reset
// with no clearing pass.
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value,
	output logic                  evicted,
	output logic [KEY_BITS-1:0]   evicted_key,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned ADR_W = IDX_W + 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// One-hot sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} lkv_state_t;

	lkv_state_t state_q;

	// Configuration and occupancy.
	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   fill_q;
	logic [ENTRIES-1:0] valid_q;

	// Captured request.
	logic                  req_action_q;
	logic [KEY_BITS-1:0]   req_key_q;
	logic [VALUE_BITS-1:0] req_value_q;

	// Sweep address and the line whose read data arrives this cycle.
	logic [ADR_W-1:0] addr_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             rd_en;
	logic             last_s1;
	logic             valid_s1;

	// Rank pass set-up.
	logic [IDX_W-1:0] tgt_q;
	logic [IDX_W-1:0] touch_q;
	logic             inc_all_q;

	// Result waiting to be offered.
	logic                res_hit_q;
	logic                res_get_hit_q;
	logic                res_ev_q;
	logic [KEY_BITS-1:0] res_evk_q;

	// Output register.
	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_ev_q;
	logic [KEY_BITS-1:0]   out_evk_q;

	lkv_store_ctl_t store_ctl;
	lkv_scan_ctl_t  scan_ctl;

	logic [KEY_BITS-1:0]   key_rd;
	logic [IDX_W-1:0]      rank_rd;
	logic [VALUE_BITS-1:0] val_rd;
	logic [IDX_W-1:0]      kv_waddr;

	logic                found;
	logic [IDX_W-1:0]    found_idx;
	logic [IDX_W-1:0]    found_rank;
	logic                victim_any;
	logic [IDX_W-1:0]    victim_idx;
	logic [KEY_BITS-1:0] victim_key;
	logic                free_any;
	logic [IDX_W-1:0]    free_idx;
	logic                rank_we;
	logic [IDX_W-1:0]    rank_waddr;
	logic [IDX_W-1:0]    rank_wdata;

	// Decision for the request, evaluated in the decide state.
	logic [CMP_W-1:0] cap_w;
	logic [CMP_W-1:0] eff_cap;
	logic             is_put;
	logic             evict;
	logic             have_slot;
	logic [IDX_W-1:0] slot_idx;
	logic             do_update;
	logic             in_take;
	logic             out_free;

	assign in_take  = in_valid && in_ready;
	assign in_ready = state_q == ST_IDLE;
	assign out_free = !out_valid_q || out_ready;

	assign rd_en    = ((state_q == ST_SEARCH) || (state_q == ST_UPDATE)) &&
	                  (addr_q < ADR_W'(ENTRIES));
	assign last_s1  = rd_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));
	assign valid_s1 = valid_q[idx_s1];

	// A capacity of zero behaves as one; anything above the line count saturates.
	always_comb begin
		cap_w = CMP_W'(cap_q);
		if (cap_w == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_w > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_w;
		end
	end

	assign is_put = req_action_q == ACT_PUT;
	assign evict  = is_put && !found && victim_any && (CMP_W'(fill_q) >= eff_cap);

	// After an eviction the first free line is either an earlier gap or the victim.
	always_comb begin
		if (evict) begin
			have_slot = 1'b1;
			slot_idx  = (free_any && (free_idx < victim_idx)) ? free_idx : victim_idx;
		end else begin
			have_slot = free_any;
			slot_idx  = free_idx;
		end
	end

	assign do_update = found || (is_put && have_slot);
	assign kv_waddr  = found ? found_idx : slot_idx;

	always_comb begin
		store_ctl         = '0;
		store_ctl.line_re = rd_en;
		if (state_q == ST_DECIDE) begin
			store_ctl.val_re = found && !is_put;
			store_ctl.val_we = is_put && (found || have_slot);
			store_ctl.key_we = is_put && !found && have_slot;
		end
	end

	always_comb begin
		scan_ctl        = '0;
		scan_ctl.clear  = in_take;
		scan_ctl.search = rd_s1 && (state_q == ST_SEARCH);
		scan_ctl.update = rd_s1 && (state_q == ST_UPDATE);
	end

	lkv_line_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk        (clk),
		.ctl        (store_ctl),
		.line_raddr (addr_q[IDX_W-1:0]),
		.val_raddr  (found_idx),
		.kv_waddr   (kv_waddr),
		.key_wdata  (req_key_q),
		.val_wdata  (req_value_q),
		.rank_we    (rank_we),
		.rank_waddr (rank_waddr),
		.rank_wdata (rank_wdata),
		.key_rdata  (key_rd),
		.rank_rdata (rank_rd),
		.val_rdata  (val_rd)
	);

	lkv_scan_unit #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx_s1     (idx_s1),
		.valid_s1   (valid_s1),
		.key_rd     (key_rd),
		.rank_rd    (rank_rd),
		.req_key    (req_key_q),
		.target_idx (tgt_q),
		.touch_rank (touch_q),
		.inc_all    (inc_all_q),
		.found      (found),
		.found_idx  (found_idx),
		.found_rank (found_rank),
		.victim_any (victim_any),
		.victim_idx (victim_idx),
		.victim_key (victim_key),
		.free_any   (free_any),
		.free_idx   (free_idx),
		.rank_we    (rank_we),
		.rank_waddr (rank_waddr),
		.rank_wdata (rank_wdata)
	);

	// Sequencer, occupancy and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			fill_q      <= '0;
			valid_q     <= '0;
			addr_q      <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rd_s1 <= rd_en;
			if (rd_en) begin
				addr_q <= addr_q + 1'b1;
			end
			// A new result is loaded when the register is free, else a taken one leaves.
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						addr_q  <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					addr_q <= '0;
					// When the victim's line is refilled it simply stays valid.
					if (evict && (victim_idx != slot_idx)) begin
						valid_q[victim_idx] <= 1'b0;
					end
					if (is_put && !found && have_slot) begin
						valid_q[slot_idx] <= 1'b1;
					end
					fill_q <= fill_q - CNT_W'(evict)
					          + CNT_W'(is_put && !found && have_slot);
					state_q <= do_update ? ST_UPDATE : ST_FINISH;
				end
				ST_UPDATE: begin
					if (last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_action_q <= action;
			req_key_q    <= key;
			req_value_q  <= value;
		end
		if (state_q == ST_DECIDE) begin
			tgt_q         <= found ? found_idx : slot_idx;
			touch_q       <= found_rank;
			inc_all_q     <= !found;
			res_hit_q     <= found;
			res_get_hit_q <= found && !is_put;
			res_ev_q      <= evict;
			res_evk_q     <= evict ? victim_key : '0;
		end
		if (rd_en) begin
			idx_s1 <= addr_q[IDX_W-1:0];
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_hit_q   <= res_hit_q;
			out_value_q <= res_get_hit_q ? val_rd : '0;
			out_ev_q    <= res_ev_q;
			out_evk_q   <= res_evk_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_hit_q;
	assign read_value  = out_value_q;
	assign evicted     = out_ev_q;
	assign evicted_key = out_evk_q;

endmodule

@@ sv/lkv_line_store.sv @@
module lkv_line_store import lkv_pkg::*; #(
	parameter int unsigned ENTRIES    = 16,
	parameter int unsigned KEY_BITS   = 16,
	parameter int unsigned VALUE_BITS = 32,
	localparam int unsigned IDX_W     = $clog2(ENTRIES)
) (
	input  logic                  clk,
	input  lkv_store_ctl_t        ctl,
	input  logic [IDX_W-1:0]      line_raddr,
	input  logic [IDX_W-1:0]      val_raddr,
	input  logic [IDX_W-1:0]      kv_waddr,
	input  logic [KEY_BITS-1:0]   key_wdata,
	input  logic [VALUE_BITS-1:0] val_wdata,
	input  logic                  rank_we,
	input  logic [IDX_W-1:0]      rank_waddr,
	input  logic [IDX_W-1:0]      rank_wdata,
	output logic [KEY_BITS-1:0]   key_rdata,
	output logic [IDX_W-1:0]      rank_rdata,
	output logic [VALUE_BITS-1:0] val_rdata
);

	logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
	logic [IDX_W-1:0]      rank_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[kv_waddr] <= key_wdata;
		end
		if (ctl.line_re) begin
			key_rdata <= key_mem[line_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[kv_waddr] <= val_wdata;
		end
		if (ctl.val_re) begin
			val_rdata <= val_mem[val_raddr];
		end
	end

	// The rank sweep writes line i while it reads line i+1, so the ports never collide.
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		if (ctl.line_re) begin
			rank_rdata <= rank_mem[line_raddr];
		end
	end

endmodule

@@ sv/lkv_scan_unit.sv @@
module lkv_scan_unit import lkv_pkg::*; #(
	parameter int unsigned ENTRIES  = 16,
	parameter int unsigned KEY_BITS = 16,
	localparam int unsigned IDX_W   = $clog2(ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lkv_scan_ctl_t       ctl,
	input  logic [IDX_W-1:0]    idx_s1,
	input  logic                valid_s1,
	input  logic [KEY_BITS-1:0] key_rd,
	input  logic [IDX_W-1:0]    rank_rd,
	input  logic [KEY_BITS-1:0] req_key,
	input  logic [IDX_W-1:0]    target_idx,
	input  logic [IDX_W-1:0]    touch_rank,
	input  logic                inc_all,
	output logic                found,
	output logic [IDX_W-1:0]    found_idx,
	output logic [IDX_W-1:0]    found_rank,
	output logic                victim_any,
	output logic [IDX_W-1:0]    victim_idx,
	output logic [KEY_BITS-1:0] victim_key,
	output logic                free_any,
	output logic [IDX_W-1:0]    free_idx,
	output logic                rank_we,
	output logic [IDX_W-1:0]    rank_waddr,
	output logic [IDX_W-1:0]    rank_wdata
);

	logic [IDX_W-1:0] victim_rank_q;
	logic             key_match;
	logic             rank_above;
	logic             rank_below;
	logic             is_target;

	assign key_match  = valid_s1 && (key_rd == req_key);
	assign rank_above = rank_rd > victim_rank_q;
	assign rank_below = rank_rd < touch_rank;
	assign is_target  = idx_s1 == target_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found      <= 1'b0;
			victim_any <= 1'b0;
			free_any   <= 1'b0;
		end else if (ctl.clear) begin
			found      <= 1'b0;
			victim_any <= 1'b0;
			free_any   <= 1'b0;
		end else if (ctl.search) begin
			if (key_match && !found) begin
				found <= 1'b1;
			end
			if (valid_s1 && (!victim_any || rank_above)) begin
				victim_any <= 1'b1;
			end
			if (!valid_s1 && !free_any) begin
				free_any <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.search) begin
			if (key_match && !found) begin
				found_idx  <= idx_s1;
				found_rank <= rank_rd;
			end
			if (valid_s1 && (!victim_any || rank_above)) begin
				victim_idx    <= idx_s1;
				victim_rank_q <= rank_rd;
				victim_key    <= key_rd;
			end
			if (!valid_s1 && !free_any) begin
				free_idx <= idx_s1;
			end
		end
	end

	// The touched line becomes rank zero; others age when they were more recent, or all valid lines age on a new key.
	assign rank_we    = ctl.update && (is_target || (valid_s1 && (inc_all || rank_below)));
	assign rank_waddr = idx_s1;
	assign rank_wdata = is_target ? '0 : rank_rd + 1'b1;

endmodule
